/* src/toeb_pkg.sv */
`timescale 1ns / 1ps

package toeb_pkg;

  // fixed widths of the request and result fields
  localparam int unsigned TIME_W = 48;
  localparam int unsigned REF_W  = 16;

  // most events one dump request may emit
  localparam int unsigned CNT_W   = 6;
  localparam logic [CNT_W-1:0] MAX_OUT = CNT_W'(32);

  // request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DUMP   = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_ALL    = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } toeb_state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // sorted insert of the new event
    logic pop;   // remove the head, everything moves one place towards it
  } cell_ctrl_t;

endpackage

/* src/toeb_cell.sv */
`timescale 1ns / 1ps

module toeb_cell
  import toeb_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctrl_t           ctrl,
  input  logic [TIME_BITS-1:0] new_time,
  input  logic [REF_W-1:0]     new_ref,
  input  logic                 left_valid,
  input  logic                 left_ge,
  input  logic [TIME_BITS-1:0] left_time,
  input  logic [REF_W-1:0]     left_ref,
  input  logic                 right_valid,
  input  logic [TIME_BITS-1:0] right_time,
  input  logic [REF_W-1:0]     right_ref,
  output logic                 valid,
  output logic                 ge,
  output logic [TIME_BITS-1:0] time_q,
  output logic [REF_W-1:0]     ref_q
);

  logic                 valid_r, valid_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [REF_W-1:0]     ref_r, ref_nxt;

  // empty, or holding a later event than the one being inserted
  assign ge = !valid_r || (time_r > new_time);

  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    ref_nxt   = ref_r;
    if (ctrl.ins) begin
      valid_nxt = valid_r || left_valid;
      if (left_ge) begin
        time_nxt = left_time;
        ref_nxt  = left_ref;
      end else if (ge) begin
        time_nxt = new_time;
        ref_nxt  = new_ref;
      end
    end else if (ctrl.pop) begin
      valid_nxt = right_valid;
      time_nxt  = right_time;
      ref_nxt   = right_ref;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    ref_r  <= ref_nxt;
  end

  assign valid  = valid_r;
  assign time_q = time_r;
  assign ref_q  = ref_r;

endmodule

/* src/time_ordered_event_buffer_core.sv */
`timescale 1ns / 1ps

// channel | dir | handshake             | payload
// request | in  | in_valid / in_stall   | req_type, event_time, event_ref, force_req, dump_limit
// result  | out | out_valid / out_stall | out_ref, out_time, out_last, out_dropped
// config  | in  | cfg_we                | cfg_index, cfg_wdata
//
// on an insert every cell compares against the new timestamp at once
// a dump emits the qualifying events from the head one after another, holding
// while the result stalls, through the single head-pop path of the cell chain;
// no request is taken meanwhile
// a refused insert (buffer full) yields one result through the output register
// rst_n is synchronous and clears the cell valid bits, state and configuration
// result stall holds the output register; requests stall while it cannot drain

module time_ordered_event_buffer_core
  import toeb_pkg::*;
#(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [TIME_W-1:0]    in_event_time,
  input  logic [REF_W-1:0]     in_event_ref,
  input  logic                 in_force_req,
  input  logic [TIME_W-1:0]    in_dump_limit,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [REF_W-1:0]     out_ref,
  output logic [TIME_W-1:0]    out_time,
  output logic                 out_last,
  output logic                 out_dropped
);

  // widest of stored and port timestamps, for zero extension both ways
  localparam int unsigned EXT_W = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;

  // configuration registers
  logic trace_r;
  logic flush_all_r;

  // dump sequencer
  toeb_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [TIME_BITS-1:0] limit_r;
  logic                 all_r;

  // output register
  logic                 out_valid_r;
  logic [REF_W-1:0]     out_ref_r;
  logic [TIME_W-1:0]    out_time_r;
  logic                 out_last_r;
  logic                 out_dropped_r;

  // cell chain
  cell_ctrl_t           ctrl;
  logic [DEPTH-1:0]     cell_valid;
  logic [DEPTH-1:0]     cell_ge;
  logic [TIME_BITS-1:0] cell_time [DEPTH];
  logic [REF_W-1:0]     cell_ref  [DEPTH];

  logic [EXT_W-1:0]     ev_ext, lim_ext, head_ext, drop_ext;
  logic [TIME_BITS-1:0] ev_time, lim_time;

  logic in_acc;
  logic out_free;
  logic full;
  logic head_ok;
  logic next_ok;
  logic emit_head;
  logic emit_drop;

  // timestamps are kept on their low TIME_BITS bits
  assign ev_ext   = EXT_W'(in_event_time);
  assign lim_ext  = EXT_W'(in_dump_limit);
  assign ev_time  = ev_ext[TIME_BITS-1:0];
  assign lim_time = lim_ext[TIME_BITS-1:0];
  assign head_ext = EXT_W'(cell_time[0]);
  // a refused event is handed back on its kept bits as well
  assign drop_ext = EXT_W'(ev_time);

  assign full     = cell_valid[DEPTH-1];
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // head qualifies for the running dump; next tells whether this one is the last
  assign head_ok = cell_valid[0] && (all_r || !(cell_time[0] > limit_r));
  assign next_ok = cell_valid[1] && (all_r || !(cell_time[1] > limit_r))
                   && ((cnt_r + CNT_W'(1)) != MAX_OUT);

  // the chain, head at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_valid, l_ge, r_valid;
    logic [TIME_BITS-1:0] l_time, r_time;
    logic [REF_W-1:0]     l_ref, r_ref;

    if (i == 0) begin : g_head
      // a virtual earliest event in front of the head
      assign l_valid = 1'b1;
      assign l_ge    = 1'b0;
      assign l_time  = '0;
      assign l_ref   = '0;
    end else begin : g_body
      assign l_valid = cell_valid[i-1];
      assign l_ge    = cell_ge[i-1];
      assign l_time  = cell_time[i-1];
      assign l_ref   = cell_ref[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_time  = '0;
      assign r_ref   = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[i+1];
      assign r_time  = cell_time[i+1];
      assign r_ref   = cell_ref[i+1];
    end

    toeb_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_time    (ev_time),
      .new_ref     (in_event_ref),
      .left_valid  (l_valid),
      .left_ge     (l_ge),
      .left_time   (l_time),
      .left_ref    (l_ref),
      .right_valid (r_valid),
      .right_time  (r_time),
      .right_ref   (r_ref),
      .valid       (cell_valid[i]),
      .ge          (cell_ge[i]),
      .time_q      (cell_time[i]),
      .ref_q       (cell_ref[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && trace_r && (in_req_type == REQ_DUMP)) begin
          state_nxt = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (out_free && (!head_ok || !next_ok)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // chain commands and result loads
  always_comb begin
    ctrl      = '0;
    emit_head = 1'b0;
    emit_drop = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && trace_r && (in_req_type == REQ_INSERT)) begin
          if (full) begin
            emit_drop = 1'b1;
          end else begin
            ctrl.ins = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        if (out_free && head_ok) begin
          emit_head = 1'b1;
          ctrl.pop  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_r     <= 1'b0;
      flush_all_r <= 1'b0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TRACE_ENABLE: trace_r     <= cfg_wdata;
          CFG_FLUSH_ALL:    flush_all_r <= cfg_wdata;
          default: ;
        endcase
      end
      state_r <= state_nxt;
      if (emit_head || emit_drop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE) begin
        cnt_r <= '0;
      end else if (emit_head) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // dump request parameters and result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      limit_r <= lim_time;
      all_r   <= in_force_req || flush_all_r;
    end
    if (emit_drop) begin
      out_ref_r     <= in_event_ref;
      out_time_r    <= drop_ext[TIME_W-1:0];
      out_last_r    <= 1'b1;
      out_dropped_r <= 1'b1;
    end else if (emit_head) begin
      out_ref_r     <= cell_ref[0];
      out_time_r    <= head_ext[TIME_W-1:0];
      out_last_r    <= !next_ok;
      out_dropped_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ref     = out_ref_r;
  assign out_time    = out_time_r;
  assign out_last    = out_last_r;
  assign out_dropped = out_dropped_r;

endmodule

/* bench/tb_time_ordered_event_buffer_core.sv */
`timescale 1ns / 1ps

module tb_time_ordered_event_buffer_core
  import toeb_pkg::*;
;

  localparam int unsigned BUF_DEPTH     = 32;
  localparam int          SETTLE_CYCLES = 40;      // settle time, covers the longest dump
  localparam int          HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic [TIME_W-1:0] STAMP_MAX = '1;

  // one request as offered on the input channel
  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] event_time;
    logic [REF_W-1:0]  event_ref;
    logic              force_req;
    logic [TIME_W-1:0] dump_limit;
  } trace_req_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [REF_W-1:0]  handle;
    logic [TIME_W-1:0] stamp;
    logic              is_last;
    logic              is_dropped;
  } event_record_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [REF_W-1:0]  handle;
  } stored_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TRACE_ENABLE;
  logic                 cfg_wdata = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = REQ_INSERT;
  logic [TIME_W-1:0]    in_event_time = '0;
  logic [REF_W-1:0]     in_event_ref = '0;
  logic                 in_force_req = 1'b0;
  logic [TIME_W-1:0]    in_dump_limit = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [REF_W-1:0]     out_ref;
  logic [TIME_W-1:0]    out_time;
  logic                 out_last;
  logic                 out_dropped;

  time_ordered_event_buffer_core #(
    .DEPTH     (BUF_DEPTH),
    .TIME_BITS (TIME_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_event_time (in_event_time),
    .in_event_ref  (in_event_ref),
    .in_force_req  (in_force_req),
    .in_dump_limit (in_dump_limit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ref       (out_ref),
    .out_time      (out_time),
    .out_last      (out_last),
    .out_dropped   (out_dropped)
  );

  // shadow of the block: sorted events, head first, and its two registers
  stored_event_t held_events[$];
  logic          trace_on  = 1'b0;
  logic          flush_all = 1'b0;

  trace_req_t    req_backlog[$];   // requests waiting for the driver
  event_record_t due_records[$];   // results predicted but not yet seen

  logic req_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   rx_mode = 0;
  int   rx_left = 0;
  logic rx_toggle = 1'b0;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // work out the results one accepted request causes and update the shadow
  task automatic predict_request(input trace_req_t r);
    int            pos;
    int            n;
    logic          take_all;
    stored_event_t ev;
    event_record_t rec;
    // with tracing off the block ignores every request
    if (!trace_on) return;
    if (r.req_type == REQ_INSERT) begin
      if (held_events.size() >= BUF_DEPTH) begin
        // full buffer: the event is refused and handed straight back
        rec = '{r.event_ref, r.event_time, 1'b1, 1'b1};
        due_records.push_back(rec);
      end else begin
        // goes behind every event with an equal or earlier stamp
        pos = held_events.size();
        while (pos > 0 && held_events[pos-1].stamp > r.event_time) pos--;
        ev = '{r.event_time, r.event_ref};
        held_events.insert(pos, ev);
      end
    end else begin
      take_all = r.force_req || flush_all;
      n = 0;
      while (n < held_events.size() && n < int'(MAX_OUT) &&
             (take_all || held_events[n].stamp <= r.dump_limit)) n++;
      // a dump that matches nothing gives no result at all
      for (int i = 0; i < n; i++) begin
        rec = '{held_events[i].handle, held_events[i].stamp, (i == n - 1), 1'b0};
        due_records.push_back(rec);
      end
      repeat (n) void'(held_events.pop_front());
    end
  endtask

  // stamps mostly from a narrow window so equal stamps and limits collide,
  // otherwise full width or the two extremes
  function automatic logic [TIME_W-1:0] rand_stamp();
    logic [63:0] wide;
    int          pick;
    pick = $urandom_range(0, 9);
    wide = {$urandom(), $urandom()};
    if (pick < 6) return TIME_W'($urandom_range(0, 31));
    if (pick < 8) return wide[TIME_W-1:0];
    return (pick == 8) ? '0 : STAMP_MAX;
  endfunction

  function automatic trace_req_t rand_request(input int insert_pct);
    trace_req_t r;
    r.req_type   = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DUMP;
    r.event_time = rand_stamp();
    r.event_ref  = REF_W'($urandom_range(0, 65535));
    r.force_req  = ($urandom_range(0, 3) == 0);
    r.dump_limit = rand_stamp();
    return r;
  endfunction

  task automatic push_insert(input logic [TIME_W-1:0] t, input logic [REF_W-1:0] h);
    req_backlog.push_back('{REQ_INSERT, t, h, 1'b0, '0});
  endtask

  task automatic push_dump(input logic f, input logic [TIME_W-1:0] lim);
    req_backlog.push_back('{REQ_DUMP, '0, '0, f, lim});
  endtask

  // register writes only happen with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TRACE_ENABLE) trace_on = val;
    else flush_all = val;
  endtask

  // sender stops until every predicted result is out and the block settles
  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid || due_records.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver: bursts of random length, random gaps in between,
  // a stalled request is held unchanged until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // keep offering the same request
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (req_backlog.size() != 0) begin
      in_req_type   <= req_backlog[0].req_type;
      in_event_time <= req_backlog[0].event_time;
      in_event_ref  <= req_backlog[0].event_ref;
      in_force_req  <= req_backlog[0].force_req;
      in_dump_limit <= req_backlog[0].dump_limit;
      void'(req_backlog.pop_front());
      in_valid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        // a quarter of the bursts follow on with no gap at all
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver: stall pattern is redrawn after each run of random length,
  // a long hold-off is served whenever one has been asked for
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_asked != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 64);
      end
      rx_left--;
      rx_toggle = ~rx_toggle;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= rx_toggle;
      endcase
    end
  end

  // acceptance of requests, checking of results and the cycle limit
  always @(posedge clk) begin
    trace_req_t    taken_req;
    event_record_t got;
    event_record_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d results still due", $time, due_records.size());
      $display("end of test: mismatches");
      $finish;
    end
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      taken_req = '{in_req_type, in_event_time, in_event_ref, in_force_req, in_dump_limit};
      predict_request(taken_req);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_ref, out_time, out_last, out_dropped};
      if (due_records.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no result, got ref=%h time=%h last=%b dropped=%b",
                 $time, got.handle, got.stamp, got.is_last, got.is_dropped);
      end else begin
        want = due_records.pop_front();
        if (got.handle !== want.handle || got.stamp !== want.stamp ||
            got.is_last !== want.is_last || got.is_dropped !== want.is_dropped) begin
          mismatch_count++;
          $display("%0t: expected ref=%h time=%h last=%b dropped=%b,",
                   $time, want.handle, want.stamp, want.is_last, want.is_dropped,
                   " got ref=%h time=%h last=%b dropped=%b",
                   got.handle, got.stamp, got.is_last, got.is_dropped);
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // tracing off: every request must vanish without trace
    write_reg(CFG_TRACE_ENABLE, 1'b0);
    write_reg(CFG_FLUSH_ALL, 1'b0);
    push_insert(TIME_W'(7), REF_W'(16'h1234));
    push_dump(1'b1, STAMP_MAX);
    wait_drained();

    // directed part: empty dumps, equal stamps, stamp and handle extremes,
    // limits just below and on a stored stamp, forced dump
    write_reg(CFG_TRACE_ENABLE, 1'b1);
    push_dump(1'b1, '0);
    push_dump(1'b0, STAMP_MAX);
    push_insert(TIME_W'(5), REF_W'(1));
    push_insert(TIME_W'(5), REF_W'(2));
    push_insert('0, '0);
    push_insert(STAMP_MAX, '1);
    push_insert(TIME_W'(3), REF_W'(3));
    push_insert(TIME_W'(5), REF_W'(4));
    push_dump(1'b0, '0);
    push_dump(1'b0, TIME_W'(2));
    push_dump(1'b0, TIME_W'(5));
    push_dump(1'b0, STAMP_MAX - 1);
    push_dump(1'b0, STAMP_MAX);
    push_insert(STAMP_MAX, REF_W'(16'haaaa));
    push_insert(TIME_W'(48'h5555_5555_5555), REF_W'(16'h5555));
    push_insert(TIME_W'(1), REF_W'(16'h8000));
    push_dump(1'b1, '0);
    wait_drained();

    // random requests, limits decide how much each dump takes
    repeat (40) req_backlog.push_back(rand_request(65));
    wait_drained();

    // receiver holds off while the buffer overflows, so refused inserts
    // back up into the request channel; a forced dump then empties it
    hold_asked++;
    repeat (2) @(posedge clk);
    repeat (40) push_insert(rand_stamp(), REF_W'($urandom_range(0, 65535)));
    push_dump(1'b1, rand_stamp());
    wait_drained();

    // every dump empties the whole buffer
    write_reg(CFG_FLUSH_ALL, 1'b1);
    repeat (30) req_backlog.push_back(rand_request(75));
    wait_drained();

    // tracing off again with the flush setting left on
    write_reg(CFG_TRACE_ENABLE, 1'b0);
    repeat (10) req_backlog.push_back(rand_request(50));
    wait_drained();

    // back to limited dumps, drain whatever is left
    write_reg(CFG_FLUSH_ALL, 1'b0);
    write_reg(CFG_TRACE_ENABLE, 1'b1);
    repeat (19) req_backlog.push_back(rand_request(60));
    push_dump(1'b1, '0);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
